FILE: sv/kvt_pkg.sv
// Package for the key/value table engine: request, response, token and entry
// types, status and operation codes, and the value byte mask helper.
// No dependencies.
package kvt_pkg;

    localparam int unsigned VALUE_BYTES = 8;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned DATA_W      = 64;

    // ASCII operation codes of a request
    localparam logic [7:0] OPC_CREATE = 8'h43;
    localparam logic [7:0] OPC_READ   = 8'h52;
    localparam logic [7:0] OPC_UPDATE = 8'h55;
    localparam logic [7:0] OPC_DELETE = 8'h44;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_FULL    = 3'd2,
        ST_MISSING = 3'd3,
        ST_BAD_LEN = 3'd4,
        ST_UNKNOWN = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_CREATE,
        OP_READ,
        OP_UPDATE,
        OP_DELETE
    } t_op;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        logic [7:0]         operation;
        logic signed [31:0] key;
        logic signed [31:0] value_length;
        logic [63:0]        value_data;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  read_length;
        logic [63:0] read_data;
    } t_rsp;

    // One table entry as held in a cell
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] value;
    } t_entry;

    // Request token that walks down the cell chain
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic              hit;   // key matched in an earlier cell
        logic              done;  // create already placed
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_tok;

    // Keep the low len bytes of a value word
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] mask;
        mask = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < len) begin
                mask[8*b +: 8] = 8'hFF;
            end
        end
        return mask;
    endfunction

endpackage

FILE: sv/kvt_cell.sv
// One table cell: holds one entry and one stage of the request token.
// Depends on kvt_pkg.
module kvt_cell #(
    parameter int unsigned CNT_W = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kvt_pkg::t_tok     i_tok,
    input  logic [CNT_W-1:0]  i_rem,
    output kvt_pkg::t_tok     o_tok,
    output logic [CNT_W-1:0]  o_rem,
    input  kvt_pkg::t_entry   i_right,
    input  logic              i_pull,
    output kvt_pkg::t_entry   o_entry,
    output logic              o_pull
);

    logic             r_valid;
    kvt_pkg::t_tok    r_tok;
    logic [CNT_W-1:0] r_rem;
    kvt_pkg::t_entry  r_ent;

    kvt_pkg::t_tok    tok;
    logic             occupied;
    logic             first_hit;
    logic             wr_create;
    logic             wr_update;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tok.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= i_tok;
        r_rem <= i_rem;
    end

    always_comb begin
        tok       = r_tok;
        tok.valid = r_valid;
        occupied  = (r_rem != '0);
        first_hit = tok.valid && occupied && !tok.hit && (r_ent.key == tok.key);
        wr_create = tok.valid && (tok.op == kvt_pkg::OP_CREATE) && !occupied
                    && !tok.hit && !tok.done;
        wr_update = first_hit && (tok.op == kvt_pkg::OP_UPDATE);
        // later occupied entries move down one place behind a deleting token
        o_pull    = tok.valid && (tok.op == kvt_pkg::OP_DELETE) && tok.hit && occupied;

        o_tok      = tok;
        o_tok.hit  = tok.hit | first_hit;
        o_tok.done = tok.done | wr_create;
        if (first_hit && (tok.op == kvt_pkg::OP_READ)) begin
            o_tok.len  = r_ent.len;
            o_tok.data = r_ent.value;
        end
        o_rem = occupied ? (r_rem - CNT_W'(1)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_pull) begin
            r_ent <= i_right;
        end else if (wr_create || wr_update) begin
            r_ent.key   <= tok.key;
            r_ent.len   <= tok.len;
            r_ent.value <= tok.data;
        end
    end

    assign o_entry = r_ent;

endmodule

FILE: sv/key_value_table_engine.sv
// Top level of the key/value table engine: request decode, result register,
// entry count and the chain of kvt_cell instances. Depends on kvt_pkg, kvt_cell.
//
// Usage
//   Requests: drive i_req and raise start; a transfer happens at a rising edge
//   where start is high and busy is low. Results: o_rsp is valid for exactly
//   one cycle while o_done is high; the receiver cannot stall it, so sample it.
//   Requests rejected by decode (negative length, over-long create or update,
//   unknown operation) give o_done in the cycle that follows the transfer edge
//   and do not raise busy, so such requests can be sent every cycle.
//   Create, read, update and delete send a token down a chain of TABLE_ENTRIES
//   cells, one cell per cycle: each cell compares the key with its own entry,
//   places a create in the first free cell, writes an update in place, captures
//   read data, and, behind a delete hit, hands each later entry to its left
//   neighbor to close the gap. The token leaves the last cell and the result is
//   then registered onto o_done; busy holds from the transfer edge until the
//   token leaves the chain, so no new table request is taken while one walks.
//   Reset (synchronous, active low) empties the table: the entry count clears;
//   entry contents are left as they are and are never read before written.
module key_value_table_engine #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  kvt_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output kvt_pkg::t_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    kvt_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_done,  n_done;
    kvt_pkg::t_rsp    r_rsp,   n_rsp;

    logic             accept;
    logic             negative;
    logic             too_long;
    logic             to_chain;
    kvt_pkg::t_status early_status;
    kvt_pkg::t_op     op;

    kvt_pkg::t_tok    w_tok  [TABLE_ENTRIES+1];
    logic [CNT_W-1:0] w_rem  [TABLE_ENTRIES+1];
    kvt_pkg::t_entry  w_ent  [TABLE_ENTRIES+1];
    logic             w_pull [TABLE_ENTRIES+1];
    kvt_pkg::t_tok    tail;

    assign busy   = (r_state == kvt_pkg::S_WALK);
    assign accept = start && !busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
    assign tail   = w_tok[TABLE_ENTRIES];

    // Decode: reject bad lengths and unknown codes before the chain
    always_comb begin
        negative     = i_req.value_length[31];
        too_long     = !negative && (i_req.value_length[30:0] > 31'(kvt_pkg::VALUE_BYTES));
        to_chain     = 1'b1;
        early_status = kvt_pkg::ST_OK;
        op           = kvt_pkg::OP_READ;
        if (negative) begin
            to_chain     = 1'b0;
            early_status = kvt_pkg::ST_BAD_LEN;
        end else begin
            case (i_req.operation)
                kvt_pkg::OPC_CREATE: begin
                    op = kvt_pkg::OP_CREATE;
                    if (too_long) begin
                        to_chain     = 1'b0;
                        early_status = kvt_pkg::ST_BAD_LEN;
                    end
                end
                kvt_pkg::OPC_READ: begin
                    op = kvt_pkg::OP_READ;
                end
                kvt_pkg::OPC_UPDATE: begin
                    op = kvt_pkg::OP_UPDATE;
                    if (too_long) begin
                        to_chain     = 1'b0;
                        early_status = kvt_pkg::ST_BAD_LEN;
                    end
                end
                kvt_pkg::OPC_DELETE: begin
                    op = kvt_pkg::OP_DELETE;
                end
                default: begin
                    to_chain     = 1'b0;
                    early_status = kvt_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    // Inject the token into the head cell; drop value bytes beyond the length
    always_comb begin
        w_tok[0].valid = accept && to_chain;
        w_tok[0].op    = op;
        w_tok[0].hit   = 1'b0;
        w_tok[0].done  = 1'b0;
        w_tok[0].key   = i_req.key;
        w_tok[0].len   = i_req.value_length[kvt_pkg::LEN_W-1:0];
        w_tok[0].data  = i_req.value_data
                         & kvt_pkg::byte_mask(i_req.value_length[kvt_pkg::LEN_W-1:0]);
    end
    assign w_rem[0]              = r_count;
    assign w_ent[TABLE_ENTRIES]  = '0;
    assign w_pull[TABLE_ENTRIES] = 1'b0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        kvt_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .i_rem   (w_rem[g]),
            .o_tok   (w_tok[g+1]),
            .o_rem   (w_rem[g+1]),
            .i_right (w_ent[g+1]),
            .i_pull  (w_pull[g+1]),
            .o_entry (w_ent[g]),
            .o_pull  (w_pull[g])
        );
    end

    // Sequencing, entry count and result register
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        case (r_state)
            kvt_pkg::S_IDLE: begin
                if (accept) begin
                    if (to_chain) begin
                        n_state = kvt_pkg::S_WALK;
                    end else begin
                        n_done             = 1'b1;
                        n_rsp.status       = early_status;
                        n_rsp.read_length  = '0;
                        n_rsp.read_data    = '0;
                    end
                end
            end
            kvt_pkg::S_WALK: begin
                if (tail.valid) begin
                    n_state           = kvt_pkg::S_IDLE;
                    n_done            = 1'b1;
                    n_rsp.read_length = '0;
                    n_rsp.read_data   = '0;
                    n_rsp.status      = tail.hit ? kvt_pkg::ST_OK : kvt_pkg::ST_MISSING;
                    case (tail.op)
                        kvt_pkg::OP_CREATE: begin
                            if (tail.hit) begin
                                n_rsp.status = kvt_pkg::ST_EXISTS;
                            end else if (tail.done) begin
                                n_rsp.status = kvt_pkg::ST_OK;
                                n_count      = r_count + CNT_W'(1);
                            end else begin
                                n_rsp.status = kvt_pkg::ST_FULL;
                            end
                        end
                        kvt_pkg::OP_READ: begin
                            if (tail.hit) begin
                                n_rsp.read_length = tail.len;
                                n_rsp.read_data   = tail.data;
                            end
                        end
                        kvt_pkg::OP_DELETE: begin
                            if (tail.hit) begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            // update: written in place, status only
                        end
                    endcase
                end
            end
            default: begin
                n_state = kvt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvt_pkg::S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_tail_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.valid |-> (r_state == kvt_pkg::S_WALK) && (w_rem[TABLE_ENTRIES] == '0))
        else $error("token left chain outside walk or with entries unvisited");

    a_head_no_pull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_pull[0])
        else $error("head cell asked to shift into nothing");

    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvt_pkg::S_WALK) && $past(r_state == kvt_pkg::S_WALK)
        |-> $stable(r_count))
        else $error("entry count changed while a token walks");

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status != kvt_pkg::ST_OK)
        |-> (o_rsp.read_length == '0) && (o_rsp.read_data == '0))
        else $error("failed request returned read data");
`endif

endmodule
